// ===== hw/rtl/ddf_pkg.sv =====
// Package for the downlink frame deframer: header phase codes, frame mode
// codes, result kinds, configuration register indexes and the mode pick.
// No dependencies.
`default_nettype none

package ddf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [PHASE_W-1:0]   t_phase;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_phase PH_HUNT   = 3'd0;
    localparam t_phase PH_ROUTE  = 3'd1;
    localparam t_phase PH_ORIGIN = 3'd2;
    localparam t_phase PH_ZERO   = 3'd3;
    localparam t_phase PH_LEN_HI = 3'd4;
    localparam t_phase PH_LEN_LO = 3'd5;

    localparam t_mode MODE_NONE      = 3'd0;
    localparam t_mode MODE_IRID_OMNI = 3'd1;
    localparam t_mode MODE_TD_OMNI   = 3'd2;
    localparam t_mode MODE_IRID_SLOW = 3'd3;
    localparam t_mode MODE_PAYLOAD   = 3'd4;

    localparam t_kind KIND_DATA     = 2'd0;
    localparam t_kind KIND_END_GOOD = 2'd1;
    localparam t_kind KIND_END_BAD  = 2'd2;

    localparam t_cfg_idx CFG_FIRST_SYNC = 3'd0;
    localparam t_cfg_idx CFG_ROUTE_IRID = 3'd1;
    localparam t_cfg_idx CFG_ROUTE_TD   = 3'd2;
    localparam t_cfg_idx CFG_ROUTE_LOW1 = 3'd3;
    localparam t_cfg_idx CFG_ROUTE_LOW2 = 3'd4;

    localparam logic [1:0] ORIGIN_SLOW = 2'd1;
    localparam logic [1:0] ORIGIN_OMNI = 2'd2;

    function automatic t_mode pick_mode(
        input logic  zero_nz,
        input t_byte route,
        input t_byte origin,
        input t_byte route_irid,
        input t_byte route_td
    );
        t_mode m;
        m = MODE_NONE;
        if (zero_nz) begin
            m = MODE_PAYLOAD;
        end else if (route == route_irid) begin
            if (origin[1:0] == ORIGIN_SLOW) begin
                m = MODE_IRID_SLOW;
            end else if (origin[1:0] == ORIGIN_OMNI) begin
                m = MODE_IRID_OMNI;
            end
        end else if (route == route_td) begin
            m = MODE_TD_OMNI;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/downlink_frame_deframer.sv =====
// Downlink frame deframer top level: header hunt, checksum and data output.
// Depends on ddf_pkg.
//
// One received byte is taken per beat and a new byte can be accepted in every
// cycle; each byte updates the registered header/frame state and any result
// lands in an output register in the cycle after acceptance. The input
// stalls only while that output register holds a result that is not taken.
// Configuration writes are taken at once (o_cfg_ready is always high) and
// must only happen while the block is idle; indexes beyond the register list
// are ignored.
`default_nettype none

module downlink_frame_deframer (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire ddf_pkg::t_cfg_idx  i_cfg_index,
    input  wire ddf_pkg::t_byte     i_cfg_data,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire ddf_pkg::t_byte     i_in_byte,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output ddf_pkg::t_kind          o_result_kind,
    output ddf_pkg::t_byte          o_data_byte,
    output ddf_pkg::t_kind          o_link_kind,
    output ddf_pkg::t_byte          o_frame_origin,
    output ddf_pkg::t_len           o_frame_length,
    output logic                    o_last
);
    import ddf_pkg::*;

    t_byte  r_first_sync, r_route_irid, r_route_td, r_route_low1, r_route_low2;

    t_phase r_phase, n_phase;
    t_byte  r_route, n_route;
    t_byte  r_origin, n_origin;
    logic   r_zero_nz, n_zero_nz;
    t_len   r_length, n_length;
    t_byte  r_sum, n_sum;
    t_mode  r_mode, n_mode;
    t_len   r_count, n_count;

    logic   r_out_valid;
    t_kind  r_kind, n_kind;
    t_byte  r_data, n_data;
    t_kind  r_link, n_link;
    t_byte  r_out_origin;
    t_len   r_out_length;
    logic   r_last, n_last;
    logic   w_load;
    logic   w_in_acc;
    t_byte  w_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_b         = i_in_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync <= '0;
            r_route_irid <= '0;
            r_route_td   <= '0;
            r_route_low1 <= '0;
            r_route_low2 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIRST_SYNC: r_first_sync <= i_cfg_data;
                CFG_ROUTE_IRID: r_route_irid <= i_cfg_data;
                CFG_ROUTE_TD:   r_route_td   <= i_cfg_data;
                CFG_ROUTE_LOW1: r_route_low1 <= i_cfg_data;
                CFG_ROUTE_LOW2: r_route_low2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_route   = r_route;
        n_origin  = r_origin;
        n_zero_nz = r_zero_nz;
        n_length  = r_length;
        n_sum     = r_sum;
        n_mode    = r_mode;
        n_count   = r_count;
        w_load    = 1'b0;
        n_kind    = KIND_DATA;
        n_data    = w_b;
        n_link    = r_mode[KIND_W-1:0] - KIND_W'(1);
        n_last    = 1'b0;
        if (w_in_acc) begin
            unique case (r_mode) inside
                MODE_NONE: begin
                    unique case (r_phase)
                        PH_HUNT: begin
                            if (w_b == r_first_sync) begin
                                n_phase = PH_ROUTE;
                            end
                        end
                        PH_ROUTE: begin
                            if (w_b == r_route_low1 || w_b == r_route_low2 ||
                                w_b == r_route_td || w_b == r_route_irid) begin
                                n_route = w_b;
                                n_phase = PH_ORIGIN;
                            end else begin
                                n_phase = PH_HUNT;
                            end
                        end
                        PH_ORIGIN: begin
                            n_origin = w_b;
                            n_sum    = w_b;
                            n_phase  = PH_ZERO;
                        end
                        PH_ZERO: begin
                            n_zero_nz = (w_b != '0);
                            n_sum     = r_sum + w_b;
                            n_phase   = PH_LEN_HI;
                        end
                        PH_LEN_HI: begin
                            n_length = {w_b, BYTE_W'(0)};
                            n_sum    = r_sum + w_b;
                            n_phase  = PH_LEN_LO;
                        end
                        PH_LEN_LO: begin
                            n_length = {r_length[LEN_W-1:BYTE_W], w_b};
                            n_sum    = r_sum + w_b;
                            n_mode   = pick_mode(r_zero_nz, r_route, r_origin,
                                                 r_route_irid, r_route_td);
                            n_count  = '0;
                            n_phase  = PH_HUNT;
                        end
                        default: n_phase = PH_HUNT;
                    endcase
                end
                MODE_IRID_OMNI, MODE_TD_OMNI, MODE_IRID_SLOW: begin
                    w_load = 1'b1;
                    if (r_count < r_length) begin
                        n_count = r_count + LEN_W'(1);
                        n_sum   = r_sum + w_b;
                    end else begin
                        n_kind    = (r_sum == w_b) ? KIND_END_GOOD : KIND_END_BAD;
                        n_last    = 1'b1;
                        n_phase   = PH_HUNT;
                        n_route   = '0;
                        n_origin  = '0;
                        n_zero_nz = 1'b0;
                        n_length  = '0;
                        n_sum     = '0;
                        n_mode    = MODE_NONE;
                        n_count   = '0;
                    end
                end
                default: begin
                    n_phase   = PH_HUNT;
                    n_route   = '0;
                    n_origin  = '0;
                    n_zero_nz = 1'b0;
                    n_length  = '0;
                    n_sum     = '0;
                    n_mode    = MODE_NONE;
                    n_count   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_route     <= '0;
            r_origin    <= '0;
            r_zero_nz   <= 1'b0;
            r_length    <= '0;
            r_sum       <= '0;
            r_mode      <= MODE_NONE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_route     <= n_route;
            r_origin    <= n_origin;
            r_zero_nz   <= n_zero_nz;
            r_length    <= n_length;
            r_sum       <= n_sum;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_out_valid <= w_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind       <= n_kind;
            r_data       <= n_data;
            r_link       <= n_link;
            r_out_origin <= r_origin;
            r_out_length <= r_length;
            r_last       <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_data_byte    = r_data;
    assign o_link_kind    = r_link;
    assign o_frame_origin = r_out_origin;
    assign o_frame_length = r_out_length;
    assign o_last         = r_last;

    a_phase_only_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HUNT |-> r_mode == MODE_NONE)
        else $error("header phase active inside a frame");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IRID_OMNI || r_mode == MODE_TD_OMNI ||
         r_mode == MODE_IRID_SLOW) |-> r_count <= r_length)
        else $error("data count past frame length");

    a_data_beat_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_mode == MODE_IRID_OMNI || r_mode == MODE_TD_OMNI ||
         r_mode == MODE_IRID_SLOW)) |=> o_out_valid)
        else $error("frame beat produced no result");

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_result_kind != KIND_DATA)))
        else $error("last flag disagrees with result kind");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_last) |=> (r_mode == MODE_NONE && r_phase == PH_HUNT))
        else $error("state not cleared after frame end");

endmodule

`default_nettype wire
